// ===== hdl/udasc_pkg.sv =====
// Package for the unsigned-to-decimal ASCII unit.
// Holds the shared digit-cell control type and the character constant.
// No dependencies.
package udasc_pkg;

  // ASCII code of '0', at the width of the character field
  localparam logic [5:0] ASCII_ZERO = 6'd48;

  // Control word for the digit cells; all cells see the same word
  typedef struct packed {
    logic clear;    // zero the digit at the start of a conversion
    logic dabble;   // add-3 correction, then shift one binary bit in
    logic advance;  // take the lower neighbor's digit during readout
  } cell_ctl_t;

endpackage

// ===== hdl/udasc_ifs.sv =====
// Handshake interfaces for the unsigned-to-decimal ASCII unit.
// udasc_in_if carries the binary value, udasc_out_if one ASCII digit.
// No dependencies.
interface udasc_in_if #(
  parameter int VALUE_WIDTH = 32
);
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface udasc_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] digit_char;
  logic       last;

  modport source (output valid, output digit_char, output last, input ready);
  modport sink   (input valid, input digit_char, input last, output ready);
endinterface

// ===== hdl/udasc_bcd_cell.sv =====
// One BCD digit cell of the double-dabble chain.
// Depends on udasc_pkg (cell_ctl_t).
module udasc_bcd_cell (
  input  logic                 clk,
  input  udasc_pkg::cell_ctl_t ctl,
  input  logic                 shift_in,
  input  logic [3:0]           digit_in,
  output logic                 carry_out,
  output logic [3:0]           digit_out
);

  logic [3:0] digit_r;
  logic [3:0] digit_nxt;
  logic [3:0] adj;

  // add-3 correction before the shift
  assign adj       = (digit_r >= 4'd5) ? (digit_r + 4'd3) : digit_r;
  assign carry_out = adj[3];
  assign digit_out = digit_r;

  always_comb begin
    digit_nxt = digit_r;
    if (ctl.clear) begin
      digit_nxt = 4'd0;
    end else if (ctl.dabble) begin
      digit_nxt = {adj[2:0], shift_in};
    end else if (ctl.advance) begin
      digit_nxt = digit_in;
    end
  end

  // digit storage, payload only
  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

endmodule

// ===== hdl/unsigned_to_decimal_ascii_unit.sv =====
// Top level of the unsigned-to-decimal ASCII unit.
// Depends on udasc_pkg, udasc_in_if, udasc_out_if and udasc_bcd_cell.
//
// Converts one unsigned VALUE_WIDTH-bit number per transaction into its
// decimal digits as ASCII '0'..'9', most significant first, leading zeros
// dropped, one output transaction per digit with last set on the final
// digit; zero gives a single '0'. A row of BCD digit cells (enough for the
// largest value, 10 at the default width) runs double dabble: one binary bit
// enters per cycle. Then, whenever the output register is free, the cells
// shift their digits upward one per cycle toward the output register, leading
// zeros being dropped one per cycle. One item is worked at a time; the next
// is taken while the final digit still waits in the output register.
module unsigned_to_decimal_ascii_unit #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  udasc_in_if.sink         in_ch,
  udasc_out_if.source      out_ch
);

  localparam int NUM_DIGITS = (VALUE_WIDTH * 1233) / 4096 + 1;
  localparam int BCW        = $clog2(VALUE_WIDTH + 1);
  localparam int DCW        = $clog2(NUM_DIGITS + 1);

  typedef enum logic [2:0] {
    ST_IDLE    = 3'b001,
    ST_CONVERT = 3'b010,
    ST_EMIT    = 3'b100
  } state_t;

  state_t                 state_r, state_nxt;
  logic [VALUE_WIDTH-1:0] sh_r, sh_nxt;
  logic [BCW-1:0]         bit_cnt_r, bit_cnt_nxt;
  logic [DCW-1:0]         dig_cnt_r, dig_cnt_nxt;
  logic                   started_r, started_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [5:0]             out_char_r, out_char_nxt;
  logic                   out_last_r, out_last_nxt;

  udasc_pkg::cell_ctl_t   cell_ctl;
  logic [NUM_DIGITS:0]    carry;
  logic [3:0]             dig [NUM_DIGITS];
  logic [3:0]             top_digit;
  logic                   in_fire;
  logic                   out_free;
  logic                   is_last;
  logic                   emit_now;

  assign in_ch.ready       = (state_r == ST_IDLE);
  assign in_fire           = in_ch.valid && in_ch.ready;
  assign out_free          = !out_valid_r || out_ch.ready;
  assign top_digit         = dig[NUM_DIGITS-1];
  assign is_last           = (dig_cnt_r == DCW'(1));
  assign emit_now          = started_r || (top_digit != 4'd0) || is_last;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.digit_char = out_char_r;
  assign out_ch.last       = out_last_r;

  // digit cell row, least significant cell first
  assign carry[0] = sh_r[VALUE_WIDTH-1];

  for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
    logic [3:0] below;
    if (i == 0) begin : g_low
      assign below = 4'd0;
    end else begin : g_up
      assign below = dig[i-1];
    end
    udasc_bcd_cell u_cell (
      .clk       (clk),
      .ctl       (cell_ctl),
      .shift_in  (carry[i]),
      .digit_in  (below),
      .carry_out (carry[i+1]),
      .digit_out (dig[i])
    );
  end

  // sequencing and output register
  always_comb begin
    state_nxt     = state_r;
    sh_nxt        = sh_r;
    bit_cnt_nxt   = bit_cnt_r;
    dig_cnt_nxt   = dig_cnt_r;
    started_nxt   = started_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    cell_ctl      = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          cell_ctl.clear = 1'b1;
          sh_nxt         = in_ch.value;
          bit_cnt_nxt    = BCW'(VALUE_WIDTH);
          state_nxt      = ST_CONVERT;
        end
      end
      ST_CONVERT: begin
        cell_ctl.dabble = 1'b1;
        sh_nxt          = {sh_r[VALUE_WIDTH-2:0], 1'b0};
        bit_cnt_nxt     = bit_cnt_r - BCW'(1);
        if (bit_cnt_r == BCW'(1)) begin
          dig_cnt_nxt = DCW'(NUM_DIGITS);
          started_nxt = 1'b0;
          state_nxt   = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          cell_ctl.advance = 1'b1;
          dig_cnt_nxt      = dig_cnt_r - DCW'(1);
          if (emit_now) begin
            started_nxt   = 1'b1;
            out_valid_nxt = 1'b1;
            out_char_nxt  = udasc_pkg::ASCII_ZERO + {2'b00, top_digit};
            out_last_nxt  = is_last;
          end
          if (is_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r       <= sh_nxt;
    bit_cnt_r  <= bit_cnt_nxt;
    dig_cnt_r  <= dig_cnt_nxt;
    started_r  <= started_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

`ifndef ASSERT_OFF
  // a taken value starts the bit loop
  a_accept_converts: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == ST_CONVERT)
    else $error("accepted value did not start conversion");

  // the bit loop ends after the last bit
  a_convert_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CONVERT) && (bit_cnt_r == BCW'(1)) |=> state_r == ST_EMIT)
    else $error("conversion did not end after the last bit");

  // the top digit cell never overflows during the bit loop
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CONVERT) |-> !carry[NUM_DIGITS])
    else $error("decimal digit row overflowed");

  // the top digit cell holds valid BCD during readout
  a_bcd_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> top_digit <= 4'd9)
    else $error("digit cell holds a non-BCD code");

  // a leading zero is dropped, never sent
  a_leading_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) && out_free && !emit_now |=> !out_valid_r)
    else $error("leading zero was emitted");
`endif

endmodule

// ===== tb/tb_top.sv =====
// Testbench for unsigned_to_decimal_ascii_unit: directed values, then random ones.
// Depends on udasc_pkg and the interfaces in udasc_ifs.sv.
// Typed answers or an internal model predict the digits, each checked in order.
module tb_top;

  localparam int VALUE_WIDTH = 32;
  localparam int RANDOM_ITEMS = 240;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 60;

  // One ASCII digit as the unit should emit it
  typedef struct packed {
    logic [5:0] digit_char;
    logic       last;
  } digit_t;

  // Directed row; an empty string means the model supplies the digits
  typedef struct {
    logic [31:0] value;
    string       digits;
  } vector_t;

  logic clk;
  logic rst_n;
  int   cycle_count = 0;
  int   mismatch_count = 0;

  digit_t  pending_digits[$];   // digits still owed by the unit
  string   typed_digits[$];     // typed-in answers, one per value sent
  vector_t directed_rows[$];

  udasc_in_if #(.VALUE_WIDTH(VALUE_WIDTH)) in_ch ();
  udasc_out_if                             out_ch ();

  unsigned_to_decimal_ascii_unit #(.VALUE_WIDTH(VALUE_WIDTH)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Clock, period 2
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Decimal digits of a value, most significant first, '0' for zero
  task automatic queue_digits_of(input logic [VALUE_WIDTH-1:0] value);
    logic [63:0] rest;
    logic [3:0]  reversed[$];
    digit_t      d;
    rest = 64'(value);
    do begin
      reversed.push_back(4'(rest % 10));
      rest = rest / 10;
    end while (rest != 0);
    while (reversed.size() > 0) begin
      d.digit_char = udasc_pkg::ASCII_ZERO + 6'(reversed.pop_back());
      d.last       = (reversed.size() == 0);
      pending_digits.push_back(d);
    end
  endtask

  // Expected digits taken straight from a typed-in string
  task automatic queue_typed(input string text);
    digit_t d;
    for (int i = 0; i < text.len(); i++) begin
      d.digit_char = 6'(text[i]);
      d.last       = (i == text.len() - 1);
      pending_digits.push_back(d);
    end
  endtask

  task automatic note_failure(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t mismatch: %s", $time, msg);
  endtask

  // Transaction monitor: checks digits, records accepted values
  always @(posedge clk) begin
    digit_t want;
    string  typed;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_digits.size() == 0) begin
          note_failure($sformatf("unexpected digit %0d last %0b",
                                 out_ch.digit_char, out_ch.last));
        end else begin
          want = pending_digits.pop_front();
          if (out_ch.digit_char !== want.digit_char || out_ch.last !== want.last)
            note_failure($sformatf("digit exp %0d/%0b got %0d/%0b",
                                   want.digit_char, want.last,
                                   out_ch.digit_char, out_ch.last));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        typed = typed_digits.pop_front();
        if (typed.len() > 0) queue_typed(typed);
        else queue_digits_of(in_ch.value);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[unsigned_to_decimal_ascii_unit] ERROR");
      $finish;
    end
  end

  // Send one value; called and returns at a falling edge
  task automatic send_value(input logic [31:0] value, input string typed, input bit steady);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    typed_digits.push_back(typed);
    in_ch.valid <= 1'b1;
    in_ch.value <= value;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Hold the input off until every owed digit has come back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (pending_digits.size() > 0);
  endtask

  // Random value: often full range, also short values and decimal edges
  function automatic logic [31:0] pick_value();
    logic [31:0] pow10;
    int          kind;
    kind = $urandom_range(0, 9);
    if (kind <= 3) return $urandom;
    if (kind <= 6) return $urandom >> $urandom_range(0, 31);
    if (kind == 7) begin
      pow10 = 1;
      repeat ($urandom_range(0, 9)) pow10 = pow10 * 10;
      return pow10 + $urandom_range(0, 2) - 1;
    end
    if (kind == 8) begin
      case ($urandom_range(0, 2))
        0: return 32'd0;
        1: return 32'hFFFF_FFFF;
        default: return 32'd1 << $urandom_range(0, 31);
      endcase
    end
    return $urandom_range(0, 99);
  endfunction

  // Result side: random stalls with steady stretches
  initial begin
    int stall;
    int taken;
    taken = 0;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      stall = ((taken / 40) % 4 == 1) ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      taken++;
      @(negedge clk);
    end
  end

  // Stimulus and end of run
  initial begin
    in_ch.valid    = 1'b0;
    in_ch.value    = '0;
    rst_n          = 1'b0;

    directed_rows = '{
      '{32'd0,          "0"},
      '{32'd1,          "1"},
      '{32'd9,          "9"},
      '{32'd10,         "10"},
      '{32'd99,         "99"},
      '{32'd100,        "100"},
      '{32'd1000,       "1000"},
      '{32'd65535,      "65535"},
      '{32'd123456789,  "123456789"},
      '{32'd999999999,  "999999999"},
      '{32'd1000000000, "1000000000"},
      '{32'd1234567890, "1234567890"},
      '{32'd2147483648, "2147483648"},
      '{32'd4000000000, "4000000000"},
      '{32'd4294967294, "4294967294"},
      '{32'd4294967295, "4294967295"},
      '{32'hAAAA_AAAA,  ""},
      '{32'h5555_5555,  ""},
      '{32'h8000_0001,  ""},
      '{32'd7,          ""},
      '{32'd0,          "0"}
    };

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed values
    foreach (directed_rows[i])
      send_value(directed_rows[i].value, directed_rows[i].digits, 1'b0);
    drain_results();

    // Random values, with one more full drain halfway
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) drain_results();
      send_value(pick_value(), "", (n / 24) % 4 == 3);
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatch_count == 0) begin
      $display("[unsigned_to_decimal_ascii_unit] OK");
    end else begin
      $display("[unsigned_to_decimal_ascii_unit] ERROR");
    end
    $finish;
  end

endmodule

// ===== unsigned_to_decimal_ascii_unit.f =====
hdl/udasc_pkg.sv
hdl/udasc_ifs.sv
hdl/udasc_bcd_cell.sv
hdl/unsigned_to_decimal_ascii_unit.sv
tb/tb_top.sv
